FILE: rtl/core/dpq_pkg.sv
`default_nettype none

package dpq_pkg;

    localparam int PEND_DEPTH = 32;
    localparam int HIST_DEPTH = 32;

    localparam int PEND_AW = $clog2(PEND_DEPTH);
    localparam int HIST_AW = $clog2(HIST_DEPTH);
    localparam int PEND_CW = $clog2(PEND_DEPTH + 1);
    localparam int HIST_CW = $clog2(HIST_DEPTH + 1);
    localparam int LEVEL_W = 6;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_PEND_FULL  = 3'd1;
    localparam logic [2:0] ST_PEND_EMPTY = 3'd2;
    localparam logic [2:0] ST_LOG_FULL   = 3'd3;
    localparam logic [2:0] ST_LOG_EMPTY  = 3'd4;

    localparam logic [2:0] DIFF_MIN = 3'd1;
    localparam logic [2:0] DIFF_MAX = 3'd5;

    typedef struct packed {
        logic [1:0]         operation;
        logic [15:0]        task_number;
        logic signed [15:0] days_left;
        logic [2:0]         task_difficulty;
    } item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [15:0]        out_number;
        logic signed [15:0] out_days;
        logic [2:0]         out_difficulty;
        logic [LEVEL_W-1:0] pending_level;
        logic [LEVEL_W-1:0] history_level;
    } result_t;

    typedef struct packed {
        logic [15:0]        number;
        logic signed [15:0] days;
        logic [2:0]         difficulty;
    } task_t;

    typedef struct packed {
        logic               we;
        logic [PEND_AW-1:0] waddr;
        task_t              wdata;
        logic               re;
        logic [PEND_AW-1:0] raddr;
    } pend_port_t;

    typedef struct packed {
        logic               we;
        logic [HIST_AW-1:0] waddr;
        task_t              wdata;
        logic               re;
        logic [HIST_AW-1:0] raddr;
    } hist_port_t;

    // strict: exact key ties keep the older entry ahead
    function automatic logic more_urgent(input task_t a, input task_t b);
        logic r;
        if (a.days != b.days)
            r = (a.days < b.days);
        else
            r = (a.difficulty > b.difficulty);
        return r;
    endfunction

    function automatic logic [2:0] clamp_diff(input logic [2:0] d);
        logic [2:0] r;
        if (d < DIFF_MIN)
            r = DIFF_MIN;
        else if (d > DIFF_MAX)
            r = DIFF_MAX;
        else
            r = d;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dpq_ram.sv
`default_nettype none

module dpq_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/dpq_ctrl.sv
`default_nettype none

module dpq_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire dpq_pkg::item_t      item,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output dpq_pkg::result_t         res,
    output dpq_pkg::pend_port_t      pend,
    input  wire dpq_pkg::task_t      pend_rdata,
    output dpq_pkg::hist_port_t      hist,
    input  wire dpq_pkg::task_t      hist_rdata
);

    import dpq_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISP     = 3'd1;
    localparam logic [2:0] S_INS_CMP  = 3'd2;
    localparam logic [2:0] S_INS_LAST = 3'd3;
    localparam logic [2:0] S_FIN      = 3'd4;
    localparam logic [2:0] S_POP      = 3'd5;
    localparam logic [2:0] S_RESP     = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [PEND_AW-1:0] p_head_reg, p_head_next;
    logic [PEND_CW-1:0] p_cnt_reg, p_cnt_next;
    logic [HIST_AW-1:0] h_head_reg, h_head_next;
    logic [HIST_CW-1:0] h_cnt_reg, h_cnt_next;

    logic [1:0]         op_reg, op_next;
    task_t              new_reg, new_next;
    logic [PEND_AW-1:0] addr_reg, addr_next;
    logic [PEND_AW-1:0] idx_reg, idx_next;
    logic [2:0]         rstat_reg, rstat_next;
    task_t              rtask_reg, rtask_next;

    logic [PEND_AW:0]   p_sum;
    logic [PEND_AW-1:0] p_tail;
    logic [HIST_AW:0]   h_sum;
    logic [HIST_AW-1:0] h_tail;

    function automatic logic [PEND_AW-1:0] pend_inc(input logic [PEND_AW-1:0] a);
        return (a == PEND_AW'(PEND_DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [PEND_AW-1:0] pend_dec(input logic [PEND_AW-1:0] a);
        return (a == '0) ? PEND_AW'(PEND_DEPTH - 1) : a - 1'b1;
    endfunction

    function automatic logic [HIST_AW-1:0] hist_inc(input logic [HIST_AW-1:0] a);
        return (a == HIST_AW'(HIST_DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    // physical slot of the last pending entry and of the next free log slot
    always_comb
    begin
        p_sum = (PEND_AW + 1)'(p_head_reg) + (PEND_AW + 1)'(p_cnt_reg - 1'b1);
        if (p_sum >= (PEND_AW + 1)'(PEND_DEPTH))
            p_sum = p_sum - (PEND_AW + 1)'(PEND_DEPTH);
        p_tail = p_sum[PEND_AW-1:0];

        h_sum = (HIST_AW + 1)'(h_head_reg) + (HIST_AW + 1)'(h_cnt_reg);
        if (h_sum >= (HIST_AW + 1)'(HIST_DEPTH))
            h_sum = h_sum - (HIST_AW + 1)'(HIST_DEPTH);
        h_tail = h_sum[HIST_AW-1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        p_head_next = p_head_reg;
        p_cnt_next  = p_cnt_reg;
        h_head_next = h_head_reg;
        h_cnt_next  = h_cnt_reg;
        op_next     = op_reg;
        new_next    = new_reg;
        addr_next   = addr_reg;
        idx_next    = idx_reg;
        rstat_next  = rstat_reg;
        rtask_next  = rtask_reg;

        pend       = '0;
        hist       = '0;
        item_stall = (state_reg != S_IDLE);
        res_valid  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    op_next             = item.operation;
                    new_next.number     = item.task_number;
                    new_next.days       = item.days_left;
                    new_next.difficulty = clamp_diff(item.task_difficulty);
                    state_next          = S_DISP;
                end
            end

            S_DISP:
            begin
                rstat_next = ST_OK;
                rtask_next = '0;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (p_cnt_reg == PEND_CW'(PEND_DEPTH))
                        begin
                            rstat_next = ST_PEND_FULL;
                            state_next = S_RESP;
                        end
                        else if (p_cnt_reg == '0)
                        begin
                            pend.we    = 1'b1;
                            pend.waddr = p_head_reg;
                            pend.wdata = new_reg;
                            p_cnt_next = p_cnt_reg + 1'b1;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            pend.re    = 1'b1;
                            pend.raddr = p_tail;
                            addr_next  = p_tail;
                            idx_next   = PEND_AW'(p_cnt_reg - 1'b1);
                            state_next = S_INS_CMP;
                        end
                    end
                    OP_FINISH:
                    begin
                        if (p_cnt_reg == '0)
                        begin
                            rstat_next = ST_PEND_EMPTY;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            pend.re    = 1'b1;
                            pend.raddr = p_head_reg;
                            state_next = S_FIN;
                        end
                    end
                    OP_POP:
                    begin
                        if (h_cnt_reg == '0)
                        begin
                            rstat_next = ST_LOG_EMPTY;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            hist.re    = 1'b1;
                            hist.raddr = h_head_reg;
                            state_next = S_POP;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            // walk from the tail toward the head, moving each less urgent entry up one slot
            S_INS_CMP:
            begin
                pend.we    = 1'b1;
                pend.waddr = pend_inc(addr_reg);
                if (more_urgent(new_reg, pend_rdata))
                begin
                    pend.wdata = pend_rdata;
                    if (idx_reg == '0)
                    begin
                        state_next = S_INS_LAST;
                    end
                    else
                    begin
                        pend.re    = 1'b1;
                        pend.raddr = pend_dec(addr_reg);
                        addr_next  = pend_dec(addr_reg);
                        idx_next   = idx_reg - 1'b1;
                    end
                end
                else
                begin
                    pend.wdata = new_reg;
                    p_cnt_next = p_cnt_reg + 1'b1;
                    state_next = S_RESP;
                end
            end

            S_INS_LAST:
            begin
                pend.we    = 1'b1;
                pend.waddr = addr_reg;
                pend.wdata = new_reg;
                p_cnt_next = p_cnt_reg + 1'b1;
                state_next = S_RESP;
            end

            S_FIN:
            begin
                rtask_next  = pend_rdata;
                p_head_next = pend_inc(p_head_reg);
                p_cnt_next  = p_cnt_reg - 1'b1;
                if (h_cnt_reg == HIST_CW'(HIST_DEPTH))
                begin
                    rstat_next = ST_LOG_FULL;
                end
                else
                begin
                    hist.we    = 1'b1;
                    hist.waddr = h_tail;
                    hist.wdata = pend_rdata;
                    h_cnt_next = h_cnt_reg + 1'b1;
                end
                state_next = S_RESP;
            end

            S_POP:
            begin
                rtask_next  = hist_rdata;
                h_head_next = hist_inc(h_head_reg);
                h_cnt_next  = h_cnt_reg - 1'b1;
                state_next  = S_RESP;
            end

            S_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.status         = rstat_reg;
        res.out_number     = rtask_reg.number;
        res.out_days       = rtask_reg.days;
        res.out_difficulty = rtask_reg.difficulty;
        res.pending_level  = LEVEL_W'(p_cnt_reg);
        res.history_level  = LEVEL_W'(h_cnt_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            p_head_reg <= '0;
            p_cnt_reg  <= '0;
            h_head_reg <= '0;
            h_cnt_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            p_head_reg <= p_head_next;
            p_cnt_reg  <= p_cnt_next;
            h_head_reg <= h_head_next;
            h_cnt_reg  <= h_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        new_reg   <= new_next;
        addr_reg  <= addr_next;
        idx_reg   <= idx_next;
        rstat_reg <= rstat_next;
        rtask_reg <= rtask_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/deadline_priority_queue_with_log.sv
// Sequence: a rejected or ignored operation, or an insert into an empty store, goes from
// dispatch straight to the result; finish and pop read their store first; any other insert
// walks from the tail toward the head, moving each entry it passes up one slot.
// Flow: one operation at a time; the next transaction is taken the cycle after the
// controller hands its result to the output register.
// Reset (rst_n, async low) clears counts, pointers and control; the task memories
// are not cleared and no clearing pass is needed.
`default_nettype none

module deadline_priority_queue_with_log (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire dpq_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output dpq_pkg::result_t      result
);

    import dpq_pkg::*;

    logic       res_valid;
    logic       res_ready;
    result_t    res;
    pend_port_t pend;
    hist_port_t hist;
    task_t      pend_rdata;
    task_t      hist_rdata;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    dpq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .pend       (pend),
        .pend_rdata (pend_rdata),
        .hist       (hist),
        .hist_rdata (hist_rdata)
    );

    dpq_ram #(
        .WIDTH ($bits(task_t)),
        .DEPTH (PEND_DEPTH)
    ) u_pend_ram (
        .clk   (clk),
        .we    (pend.we),
        .waddr (pend.waddr),
        .wdata (pend.wdata),
        .re    (pend.re),
        .raddr (pend.raddr),
        .rdata (pend_rdata)
    );

    dpq_ram #(
        .WIDTH ($bits(task_t)),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist.we),
        .waddr (hist.waddr),
        .wdata (hist.wdata),
        .re    (hist.re),
        .raddr (hist.raddr),
        .rdata (hist_rdata)
    );

    // output register: free when empty or being taken this cycle
    assign res_ready = !out_valid_reg || !result_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/dpq_check.sv
`default_nettype none

module dpq_check (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire logic             item_stall,
    input  wire dpq_pkg::item_t   item,
    input  wire logic             result_valid,
    input  wire logic             result_stall,
    input  wire dpq_pkg::result_t result
);

    import dpq_pkg::*;

    // a stalled input transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("stalled input changed");

    // a stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // rejected operations return no task
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == ST_PEND_FULL || result.status == ST_PEND_EMPTY
                         || result.status == ST_LOG_EMPTY)
        |-> result.out_difficulty == 3'd0 && result.out_number == 16'd0
            && result.out_days == 16'sd0)
        else $error("task returned on rejected operation");

    // an unlogged finish only happens with a full log, and returns a real task
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_LOG_FULL
        |-> result.history_level == LEVEL_W'(HIST_DEPTH) && result.out_difficulty != 3'd0)
        else $error("log-full status inconsistent");

    // levels never exceed the store depths
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.pending_level <= LEVEL_W'(PEND_DEPTH)
                         && result.history_level <= LEVEL_W'(HIST_DEPTH))
        else $error("level out of range");

endmodule

bind deadline_priority_queue_with_log dpq_check u_dpq_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

FILE: verif/deadline_priority_queue_with_log_tb.sv
`timescale 1ns / 1ps

module deadline_priority_queue_with_log_tb;

    import dpq_pkg::*;

    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam int RANDOM_OPS = 1250;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 40;

    typedef enum int { PH_FILL, PH_DRAIN, PH_UNLOAD, PH_MIXED } phase_e;

    typedef struct {
        item_t   op_in;
        bit      typed;
        result_t want;
    } dir_row_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // predictor state
    task_t pend_tasks[PEND_DEPTH];
    int    pend_cnt;
    task_t hist_tasks[HIST_DEPTH];
    int    hist_head;
    int    hist_cnt;

    result_t  due_results[$];
    dir_row_t dir_rows[$];
    int       status_hits[5];
    int       err_cnt;
    int       results_seen;
    int       dir_sent;
    int       rand_sent;
    int       send_idle;

    result_t  got_want;
    int       rx_left;
    int       rx_tick;
    bit       rx_calm;
    int       rx_roll;

    deadline_priority_queue_with_log dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    function automatic item_t mk_item(input logic [1:0] op, input logic [15:0] num,
                                      input logic signed [15:0] days,
                                      input logic [2:0] diff);
        item_t x;
        x.operation       = op;
        x.task_number     = num;
        x.days_left       = days;
        x.task_difficulty = diff;
        return x;
    endfunction

    function automatic void add_row(input item_t it, input bit typed,
                                    input logic [2:0] st, input logic [5:0] plev,
                                    input logic [5:0] hlev);
        dir_row_t r;
        r.op_in = it;
        r.typed = typed;
        r.want  = '0;
        r.want.status        = st;
        r.want.pending_level = plev;
        r.want.history_level = hlev;
        dir_rows.push_back(r);
    endfunction

    // one operation on the shadow queue and log; returns the result it yields
    function automatic result_t queue_step(input item_t it);
        result_t r;
        task_t   t;
        int      pos;
        r = '0;
        case (it.operation)
            OP_INSERT: begin
                if (pend_cnt >= PEND_DEPTH) begin
                    r.status = ST_PEND_FULL;
                end else begin
                    t.number = it.task_number;
                    t.days   = it.days_left;
                    if (it.task_difficulty < DIFF_MIN)
                        t.difficulty = DIFF_MIN;
                    else if (it.task_difficulty > DIFF_MAX)
                        t.difficulty = DIFF_MAX;
                    else
                        t.difficulty = it.task_difficulty;
                    // walk past everything at least as urgent (older entries win ties)
                    pos = 0;
                    while (pos < pend_cnt &&
                           (pend_tasks[pos].days < t.days ||
                            (pend_tasks[pos].days == t.days &&
                             pend_tasks[pos].difficulty >= t.difficulty)))
                        pos++;
                    for (int i = pend_cnt; i > pos; i--)
                        pend_tasks[i] = pend_tasks[i-1];
                    pend_tasks[pos] = t;
                    pend_cnt++;
                end
            end
            OP_FINISH: begin
                if (pend_cnt == 0) begin
                    r.status = ST_PEND_EMPTY;
                end else begin
                    t = pend_tasks[0];
                    for (int i = 0; i + 1 < pend_cnt; i++)
                        pend_tasks[i] = pend_tasks[i+1];
                    pend_cnt--;
                    r.out_number     = t.number;
                    r.out_days       = t.days;
                    r.out_difficulty = t.difficulty;
                    if (hist_cnt >= HIST_DEPTH) begin
                        r.status = ST_LOG_FULL;
                    end else begin
                        hist_tasks[(hist_head + hist_cnt) % HIST_DEPTH] = t;
                        hist_cnt++;
                    end
                end
            end
            OP_POP: begin
                if (hist_cnt == 0) begin
                    r.status = ST_LOG_EMPTY;
                end else begin
                    t = hist_tasks[hist_head];
                    r.out_number     = t.number;
                    r.out_days       = t.days;
                    r.out_difficulty = t.difficulty;
                    hist_head = (hist_head + 1) % HIST_DEPTH;
                    hist_cnt--;
                end
            end
            default: ;
        endcase
        r.pending_level = LEVEL_W'(pend_cnt);
        r.history_level = LEVEL_W'(hist_cnt);
        status_hits[r.status]++;
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (send_idle == 0)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [1:0] pick_op(input phase_e ph);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return OP_IGNORED;
        case (ph)
            PH_FILL:   return (roll < 85) ? OP_INSERT : (roll < 95) ? OP_FINISH : OP_POP;
            PH_DRAIN:  return (roll < 12) ? OP_INSERT : OP_FINISH;
            PH_UNLOAD: return (roll < 7) ? OP_INSERT : (roll < 12) ? OP_FINISH : OP_POP;
            default:   return (roll < 40) ? OP_INSERT : (roll < 70) ? OP_FINISH : OP_POP;
        endcase
    endfunction

    function automatic logic signed [15:0] pick_days();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 16'sh8000;
        else if (roll == 1)
            return 16'sh7FFF;
        else if (roll < 6)
            return 16'($signed($urandom_range(0, 6)) - 3);   // dense keys force ties
        return 16'($urandom());
    endfunction

    task automatic send_op(input item_t it, input int gap, input bit typed,
                           input result_t want);
        result_t pred;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        pred = queue_step(it);
        due_results.push_back(typed ? want : pred);
    endtask

    function automatic void cmp_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: mismatch on %s: expected %h, got %h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected transaction on result: expected none, got %h",
                         $time, result);
                err_cnt++;
            end
            else
            begin
                got_want = due_results.pop_front();
                cmp_field("status", 16'(got_want.status), 16'(result.status));
                cmp_field("out_number", got_want.out_number, result.out_number);
                cmp_field("out_days", got_want.out_days, result.out_days);
                cmp_field("out_difficulty", 16'(got_want.out_difficulty),
                          16'(result.out_difficulty));
                cmp_field("pending_level", 16'(got_want.pending_level),
                          16'(result.pending_level));
                cmp_field("history_level", 16'(got_want.history_level),
                          16'(result.history_level));
            end
        end
    end

    // receiver backpressure: calm stretches, short stalls, occasional long ones
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            rx_left      <= 0;
            rx_tick      <= 0;
            rx_calm      <= 1'b0;
        end
        else
        begin
            rx_tick <= rx_tick + 1;
            if (rx_tick % 200 == 199)
                rx_calm <= ($urandom_range(0, 3) == 0);
            if (rx_left > 0)
            begin
                rx_left      <= rx_left - 1;
                result_stall <= 1'b1;
            end
            else if (rx_calm)
            begin
                result_stall <= 1'b0;
            end
            else
            begin
                rx_roll = $urandom_range(0, 99);
                if (rx_roll < 70)
                begin
                    result_stall <= 1'b0;
                end
                else if (rx_roll < 95)
                begin
                    result_stall <= 1'b1;
                    rx_left      <= $urandom_range(0, 2);
                end
                else
                begin
                    result_stall <= 1'b1;
                    rx_left      <= $urandom_range(8, 30);
                end
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: run timed out with %0d transactions outstanding",
                 $time, due_results.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        phase_e ph;
        int     ph_len;
        int     ph_num;
        item_t  it;

        pend_cnt  = 0;
        hist_cnt  = 0;
        hist_head = 0;
        err_cnt   = 0;
        send_idle = 0;
        foreach (status_hits[i])
            status_hits[i] = 0;

        // empty-state behavior, operation three, key extremes, difficulty clamping,
        // exact ties, then drain both stores past empty
        add_row(mk_item(OP_FINISH, 16'h0000, 16'sh0000, 3'd1), 1'b1, ST_PEND_EMPTY, 0, 0);
        add_row(mk_item(OP_POP, 16'h0000, 16'sh0000, 3'd1), 1'b1, ST_LOG_EMPTY, 0, 0);
        add_row(mk_item(OP_IGNORED, 16'hFFFF, 16'shFFFF, 3'd7), 1'b1, ST_OK, 0, 0);
        add_row(mk_item(OP_INSERT, 16'hFFFF, 16'sh7FFF, 3'd0), 1'b0, ST_OK, 0, 0);
        add_row(mk_item(OP_INSERT, 16'h0000, 16'sh8000, 3'd7), 1'b0, ST_OK, 0, 0);
        add_row(mk_item(OP_INSERT, 16'h1234, 16'sh0005, 3'd6), 1'b0, ST_OK, 0, 0);
        add_row(mk_item(OP_INSERT, 16'h5678, 16'sh0005, 3'd5), 1'b0, ST_OK, 0, 0);
        add_row(mk_item(OP_INSERT, 16'h9ABC, 16'sh0005, 3'd3), 1'b0, ST_OK, 0, 0);
        add_row(mk_item(OP_INSERT, 16'h0F0F, 16'sh0005, 3'd5), 1'b0, ST_OK, 0, 0);
        repeat (6)
            add_row(mk_item(OP_FINISH, 16'hA5A5, 16'sh5A5A, 3'd2), 1'b0, ST_OK, 0, 0);
        add_row(mk_item(OP_FINISH, 16'h0000, 16'sh0000, 3'd1), 1'b1, ST_PEND_EMPTY, 0, 6);
        repeat (6)
            add_row(mk_item(OP_POP, 16'h5A5A, 16'shA5A5, 3'd4), 1'b0, ST_OK, 0, 0);
        add_row(mk_item(OP_POP, 16'h0000, 16'sh0000, 3'd1), 1'b1, ST_LOG_EMPTY, 0, 0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            send_op(dir_rows[i].op_in, 0, dir_rows[i].typed, dir_rows[i].want);
            dir_sent++;
        end

        ph_num = 0;
        while (rand_sent < RANDOM_OPS)
        begin
            case (ph_num % 4)
                0:       ph = PH_UNLOAD;
                1:       ph = PH_FILL;
                2:       ph = PH_DRAIN;
                default: ph = PH_MIXED;
            endcase
            ph_len    = $urandom_range(40, 120);
            send_idle = $urandom_range(0, 3);
            repeat (ph_len)
            begin
                it = mk_item(pick_op(ph), 16'($urandom()), pick_days(),
                             3'($urandom_range(0, 7)));
                send_op(it, pick_gap(), 1'b0, '0);
                if (it.operation != OP_IGNORED)
                    rand_sent++;
            end
            // every third phase, hold off until the block has delivered everything
            if (ph_num % 3 == 2)
            begin
                item_valid <= 1'b0;
                while (due_results.size() != 0) @(posedge clk);
            end
            ph_num++;
        end

        item_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d directed and %0d random operations over %0d phases; %0d results checked.",
                 dir_sent, rand_sent, ph_num, results_seen);
        $display("Statuses seen: ok %0d, pending full %0d, pending empty %0d, log full %0d, log empty %0d; %0d mismatches.",
                 status_hits[ST_OK], status_hits[ST_PEND_FULL], status_hits[ST_PEND_EMPTY],
                 status_hits[ST_LOG_FULL], status_hits[ST_LOG_EMPTY], err_cnt);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/dpq_pkg.sv
rtl/core/dpq_ram.sv
rtl/core/dpq_ctrl.sv
rtl/core/deadline_priority_queue_with_log.sv
rtl/core/dpq_check.sv
verif/deadline_priority_queue_with_log_tb.sv
